// File: rtl/vcdsr_pkg.sv
// Package for the value change dump run extractor.
// Holds default sizes, the configuration map and the character codes.
// No dependencies.
package vcdsr_pkg;

    localparam int PROBES_DEF   = 8;
    localparam int ID_CHARS_DEF = 4;

    // Configuration map: probe_id_0 .. probe_id_7 at indexes 0 .. 7.
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int REG_W     = 32;

    localparam int STAMP_W  = 64;
    localparam int SAMPLE_W = 8;
    localparam int BYTE_W   = 8;
    localparam int WINDOW_W = 24;

    localparam logic [WINDOW_W-1:0] WINDOW_DOLLAR_EN = 24'h24656E;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LO_D   = 8'h64;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [1:0] {
        KIND_OTHER     = 2'd0,
        KIND_STAMP     = 2'd1,
        KIND_DIRECTIVE = 2'd2,
        KIND_VALUE     = 2'd3
    } token_kind_t;

endpackage

// File: rtl/vcd_value_change_to_sample_runs_top.sv
// Value change dump run extractor, top level.
// Tokenizes the dump's data section and emits runs of held probe levels.
// Depends on vcdsr_pkg.
//
// Takes one text byte per cycle on the slave stream and returns a run on the
// master stream for each timestamp after the first that differs from the one
// before; the run carries the probe levels held until then and the tick count
// between the two stamps. All parsing of a byte happens in the cycle of its
// transfer against the parser registers, and the run lands in an output
// register, so a byte is taken every cycle; the input stalls only while that
// output register is full and the downstream side does not take it. The run
// appears in the cycle after the stamp-ending white space byte. The user must
// write probe identifiers through the configuration port only while no byte is
// in flight (the block does not check); a write to an index at or beyond PROBES is ignored.
module vcd_value_change_to_sample_runs_top #(
    parameter int PROBES   = vcdsr_pkg::PROBES_DEF,
    parameter int ID_CHARS = vcdsr_pkg::ID_CHARS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration writes
    input  logic                           cfg_wen,
    input  logic [vcdsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vcdsr_pkg::REG_W-1:0]     cfg_wdata,
    // text byte stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] text_byte
    // run stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [71:0]                    m_tdata    // [7:0] sample_bits, [71:8] run_length
);

    localparam int IDW   = 8 * ID_CHARS;
    localparam int CMP_W = (IDW > vcdsr_pkg::REG_W) ? IDW : vcdsr_pkg::REG_W;
    localparam int LEN_W = $clog2(ID_CHARS + 1);
    localparam int SW    = vcdsr_pkg::STAMP_W;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_TOKEN  = 3'd1,
        MODE_IDWAIT = 3'd2,
        MODE_IDENT  = 3'd3,
        MODE_SKIP   = 3'd4
    } mode_t;

    mode_t                            mode_reg, mode_next;
    vcdsr_pkg::token_kind_t           kind_reg, kind_next;
    logic [LEN_W-1:0]                 len_reg, len_next;
    logic [SW-1:0]                    stamp_reg, stamp_next;
    logic                             ended_reg, ended_next;
    logic [SW-1:0]                    last_reg, last_next;
    logic                             seen_reg, seen_next;
    logic [PROBES-1:0]                levels_reg, levels_next;
    logic [IDW-1:0]                   ident_reg, ident_next;
    logic                             long_reg, long_next;
    logic                             pending_reg, pending_next;
    logic [vcdsr_pkg::WINDOW_W-1:0]   window_reg, window_next;
    logic [vcdsr_pkg::REG_W-1:0]      probe_id_reg [PROBES];

    logic                             out_valid_reg;
    logic [vcdsr_pkg::SAMPLE_W-1:0]   out_sample_reg;
    logic [SW-1:0]                    out_run_reg;

    logic                             accept;
    logic                             out_load;
    logic [7:0]                       c;
    logic                             ws;
    logic                             digit;
    logic                             value_char;
    logic [SW+3:0]                    mac;
    logic [SW-1:0]                    stamp_step;
    logic [SW-1:0]                    run;
    logic [IDW-1:0]                   add_buf;
    logic [LEN_W-1:0]                 add_len;
    logic                             add_long;
    logic [CMP_W-1:0]                 ident_cmp;
    logic [CMP_W-1:0]                 id_cmp;
    logic                             hit;
    logic [PROBES-1:0]                matched_levels;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_run_reg, out_sample_reg};

    assign c     = s_tdata;
    assign ws    = (c == vcdsr_pkg::CH_SPACE) ||
                   (c >= vcdsr_pkg::CH_TAB && c <= vcdsr_pkg::CH_CR);
    assign digit = (c >= vcdsr_pkg::CH_ZERO) && (c <= vcdsr_pkg::CH_NINE);
    assign value_char = (c == vcdsr_pkg::CH_ZERO) || (c == vcdsr_pkg::CH_ONE) ||
                        (c == vcdsr_pkg::CH_LO_X) || (c == vcdsr_pkg::CH_UP_X) ||
                        (c == vcdsr_pkg::CH_LO_Z) || (c == vcdsr_pkg::CH_UP_Z);

    // accum * 10 + digit; anything past 64 bits saturates
    assign mac = ({4'b0, stamp_reg} << 3) + ({4'b0, stamp_reg} << 1)
               + {{(SW - 4){1'b0}}, 4'b0, (c[3:0] - vcdsr_pkg::CH_ZERO[3:0])};
    assign stamp_step = (|mac[SW+3:SW]) ? {SW{1'b1}} : mac[SW-1:0];

    assign run = stamp_reg - last_reg;

    // append one character to the identifier buffer
    always_comb
    begin
        add_buf  = ident_reg;
        add_len  = len_reg;
        add_long = long_reg;
        if (len_reg < LEN_W'(ID_CHARS))
        begin
            for (int j = 0; j < ID_CHARS; j++)
            begin
                if (len_reg == LEN_W'(j))
                begin
                    add_buf[j*8 +: 8] = c;
                end
            end
            add_len = len_reg + LEN_W'(1);
        end
        else
        begin
            add_long = 1'b1;
        end
    end

    // first probe whose identifier equals the buffer takes the pending level
    always_comb
    begin
        ident_cmp      = CMP_W'(ident_reg);
        hit            = 1'b0;
        matched_levels = levels_reg;
        id_cmp         = '0;
        for (int k = 0; k < PROBES; k++)
        begin
            id_cmp = CMP_W'(probe_id_reg[k]);
            if (!hit && !long_reg && (probe_id_reg[k] != '0) && (id_cmp == ident_cmp))
            begin
                hit               = 1'b1;
                matched_levels[k] = pending_reg;
            end
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        kind_next    = kind_reg;
        len_next     = len_reg;
        stamp_next   = stamp_reg;
        ended_next   = ended_reg;
        last_next    = last_reg;
        seen_next    = seen_reg;
        levels_next  = levels_reg;
        ident_next   = ident_reg;
        long_next    = long_reg;
        pending_next = pending_reg;
        window_next  = window_reg;
        out_load     = 1'b0;
        if (accept)
        begin
            unique case (mode_reg)
                MODE_TOKEN:
                begin
                    if (ws)
                    begin
                        mode_next = MODE_IDLE;
                        case (kind_reg)
                            vcdsr_pkg::KIND_STAMP:
                            begin
                                if (len_reg != '0)
                                begin
                                    if (seen_reg)
                                    begin
                                        out_load = (run != '0);
                                    end
                                    seen_next = 1'b1;
                                    last_next = stamp_reg;
                                end
                            end
                            vcdsr_pkg::KIND_DIRECTIVE:
                            begin
                                mode_next   = MODE_SKIP;
                                window_next = '0;
                            end
                            vcdsr_pkg::KIND_VALUE:
                            begin
                                if (len_reg == '0 && !long_reg)
                                begin
                                    mode_next = MODE_IDWAIT;
                                end
                                else
                                begin
                                    levels_next = matched_levels;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    else if (kind_reg == vcdsr_pkg::KIND_STAMP)
                    begin
                        if (len_reg == '0 && !digit)
                        begin
                            kind_next = vcdsr_pkg::KIND_OTHER;
                        end
                        else
                        begin
                            len_next = LEN_W'(1);
                            if (!ended_reg)
                            begin
                                if (digit)
                                begin
                                    stamp_next = stamp_step;
                                end
                                else
                                begin
                                    ended_next = 1'b1;
                                end
                            end
                        end
                    end
                    else if (kind_reg == vcdsr_pkg::KIND_VALUE)
                    begin
                        ident_next = add_buf;
                        len_next   = add_len;
                        long_next  = add_long;
                    end
                end
                MODE_IDWAIT:
                begin
                    if (!ws)
                    begin
                        ident_next        = '0;
                        ident_next[7:0]   = c;
                        len_next          = LEN_W'(1);
                        long_next         = 1'b0;
                        stamp_next        = '0;
                        ended_next        = 1'b0;
                        mode_next         = MODE_IDENT;
                    end
                end
                MODE_IDENT:
                begin
                    if (ws)
                    begin
                        levels_next = matched_levels;
                        mode_next   = MODE_IDLE;
                    end
                    else
                    begin
                        ident_next = add_buf;
                        len_next   = add_len;
                        long_next  = add_long;
                    end
                end
                MODE_SKIP:
                begin
                    if (window_reg == vcdsr_pkg::WINDOW_DOLLAR_EN && c == vcdsr_pkg::CH_LO_D)
                    begin
                        mode_next   = MODE_IDLE;
                        window_next = '0;
                    end
                    else
                    begin
                        window_next = {window_reg[15:0], c};
                    end
                end
                default:
                begin
                    // idle, and any stray mode code
                    mode_next = MODE_IDLE;
                    if (!ws)
                    begin
                        len_next   = '0;
                        ident_next = '0;
                        long_next  = 1'b0;
                        stamp_next = '0;
                        ended_next = 1'b0;
                        if (c == vcdsr_pkg::CH_HASH)
                        begin
                            kind_next = vcdsr_pkg::KIND_STAMP;
                        end
                        else if (c == vcdsr_pkg::CH_DOLLAR)
                        begin
                            kind_next = vcdsr_pkg::KIND_DIRECTIVE;
                        end
                        else if (value_char)
                        begin
                            kind_next    = vcdsr_pkg::KIND_VALUE;
                            pending_next = (c == vcdsr_pkg::CH_ONE);
                        end
                        else
                        begin
                            kind_next = vcdsr_pkg::KIND_OTHER;
                        end
                        mode_next = MODE_TOKEN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            kind_reg      <= vcdsr_pkg::KIND_OTHER;
            len_reg       <= '0;
            stamp_reg     <= '0;
            ended_reg     <= 1'b0;
            last_reg      <= '0;
            seen_reg      <= 1'b0;
            levels_reg    <= '0;
            ident_reg     <= '0;
            long_reg      <= 1'b0;
            pending_reg   <= 1'b0;
            window_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < PROBES; k++)
            begin
                probe_id_reg[k] <= '0;
            end
        end
        else
        begin
            mode_reg    <= mode_next;
            kind_reg    <= kind_next;
            len_reg     <= len_next;
            stamp_reg   <= stamp_next;
            ended_reg   <= ended_next;
            last_reg    <= last_next;
            seen_reg    <= seen_next;
            levels_reg  <= levels_next;
            ident_reg   <= ident_next;
            long_reg    <= long_next;
            pending_reg <= pending_next;
            window_reg  <= window_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wen)
            begin
                for (int k = 0; k < PROBES; k++)
                begin
                    if (cfg_index == vcdsr_pkg::CFG_IDX_W'(k))
                    begin
                        probe_id_reg[k] <= cfg_wdata;
                    end
                end
            end
        end
    end

    // result payload, loaded with the run
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sample_reg <= vcdsr_pkg::SAMPLE_W'(levels_reg);
            out_run_reg    <= run;
        end
    end

endmodule
